/* rtl/vbst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbst_pkg: shared constants and types for the volume blob solitary test
// Field widths, register map, verdict codes and sequencer states.
// ----------------------------------------------------------------------------
package vbst_pkg;

  localparam int VOXEL_W = 8;
  localparam int DIM_W   = 9;
  localparam int COUNT_W = 25;
  localparam int EXT_W   = 9;
  localparam int VERD_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam int MAX_DIM_DEFAULT = 256;

  localparam logic [DIM_W-1:0]   DIM_RESET      = 9'd64;
  localparam logic [COUNT_W-1:0] MAX_SIZE_RESET = 25'd1000;
  localparam logic [COUNT_W-1:0] COUNT_SAT      = '1;
  localparam logic [EXT_W-1:0]   EXT_SAT        = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_X    = 2'd0,
    REG_DIM_Y    = 2'd1,
    REG_DIM_Z    = 2'd2,
    REG_MAX_SIZE = 2'd3
  } reg_idx_t;

  typedef enum logic [VERD_W-1:0] {
    VERD_SOLITARY    = 3'd0,
    VERD_TOO_LARGE   = 3'd1,
    VERD_TOUCHES     = 3'd2,
    VERD_EMPTY       = 3'd3,
    VERD_NOT_COMPACT = 3'd4
  } verdict_t;

  typedef enum logic [3:0] {
    ST_ACCUM = 4'b0001,
    ST_MUL1  = 4'b0010,
    ST_MUL2  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

/* rtl/vbst_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbst_in_if: voxel input channel
// Valid/ready channel carrying one voxel label per transaction.
// ----------------------------------------------------------------------------
interface vbst_in_if;
  logic                         valid;
  logic                         ready;
  logic [vbst_pkg::VOXEL_W-1:0] voxel;

  modport source (output valid, output voxel, input ready);
  modport sink   (input valid, input voxel, output ready);
endinterface

/* rtl/vbst_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbst_out_if: verdict output channel
// Valid/ready channel carrying one verdict per volume.
// ----------------------------------------------------------------------------
interface vbst_out_if;
  logic                         valid;
  logic                         ready;
  logic                         solitary;
  logic [vbst_pkg::VERD_W-1:0]  verdict;
  logic [vbst_pkg::COUNT_W-1:0] fg_count;
  logic [vbst_pkg::EXT_W-1:0]   extent_x;
  logic [vbst_pkg::EXT_W-1:0]   extent_y;
  logic [vbst_pkg::EXT_W-1:0]   extent_z;

  modport source (output valid, output solitary, output verdict, output fg_count,
                  output extent_x, output extent_y, output extent_z, input ready);
  modport sink   (input valid, input solitary, input verdict, input fg_count,
                  input extent_x, input extent_y, input extent_z, output ready);
endinterface

/* rtl/volume_blob_solitary_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_blob_solitary_test_top: solitary-blob test on a streamed label volume
// Tracks raster position, foreground count, face contact and bounding box;
// gives one verdict per volume using a shared multiplier for box volume.
// ----------------------------------------------------------------------------
// Throughput: one voxel per cycle inside a volume. After the final voxel the
//   input stalls in MUL1 and MUL2 (two passes through the shared multiplier:
//   ext_x*ext_y, then *ext_z) and in DONE, which loads the result register
//   once the output register is free.
// Reset (rst, synchronous): position and accumulators cleared, registers
//   back to 64/64/64/1000, output register empty.
// ----------------------------------------------------------------------------
module volume_blob_solitary_test_top #(
  parameter int MAX_DIM = vbst_pkg::MAX_DIM_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vbst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbst_pkg::CFG_DATA_W-1:0] cfg_data,
  vbst_in_if.sink                         in_ch,
  vbst_out_if.source                      out_ch
);

  // Position width, extent width (holds MAX_DIM), compare width for dims.
  localparam int PW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int EW = PW + 1;
  localparam int CW = (EW > vbst_pkg::DIM_W) ? EW : vbst_pkg::DIM_W;
  // Shared multiplier: (2*EW) x EW bits.
  localparam int PRW = 3 * EW;
  localparam int FW  = vbst_pkg::COUNT_W + 2;
  localparam int MW  = (PRW > FW) ? PRW : FW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [vbst_pkg::DIM_W-1:0]   dim [3];
  logic [vbst_pkg::COUNT_W-1:0] max_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim[0]   <= vbst_pkg::DIM_RESET;
      dim[1]   <= vbst_pkg::DIM_RESET;
      dim[2]   <= vbst_pkg::DIM_RESET;
      max_size <= vbst_pkg::MAX_SIZE_RESET;
    end else if (cfg_we) begin
      case (vbst_pkg::reg_idx_t'(cfg_index))
        vbst_pkg::REG_DIM_X:    dim[0]   <= cfg_data[vbst_pkg::DIM_W-1:0];
        vbst_pkg::REG_DIM_Y:    dim[1]   <= cfg_data[vbst_pkg::DIM_W-1:0];
        vbst_pkg::REG_DIM_Z:    dim[2]   <= cfg_data[vbst_pkg::DIM_W-1:0];
        vbst_pkg::REG_MAX_SIZE: max_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Raster position and per-voxel accumulation
  // --------------------------------------------------------------------------
  vbst_pkg::state_t             state;
  logic [PW-1:0]                pos [3];
  logic [PW-1:0]                pos_next [3];
  logic [PW-1:0]                box_min [3];
  logic [PW-1:0]                box_max [3];
  logic [PW-1:0]                box_min_next [3];
  logic [PW-1:0]                box_max_next [3];
  logic [vbst_pkg::COUNT_W-1:0] fg_total, fg_total_next;
  logic                         face_hit, face_hit_next;
  logic [CW-1:0]                eff_dim [3];
  logic [2:0]                   last;
  logic                         fg, on_face, in_acc, vol_end;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign fg      = (in_ch.voxel != '0);
  assign vol_end = &last;

  // Effective dimension: 0 acts as 1, anything above MAX_DIM as MAX_DIM.
  // A position at or past dim-1 counts as last on its axis.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (dim[a] == '0)
        eff_dim[a] = CW'(1);
      else if (CW'(dim[a]) > CW'(MAX_DIM))
        eff_dim[a] = CW'(MAX_DIM);
      else
        eff_dim[a] = CW'(dim[a]);
      last[a] = (CW'(pos[a]) >= (eff_dim[a] - CW'(1)));
    end
  end

  always_comb begin
    on_face = 1'b0;
    for (int a = 0; a < 3; a++)
      on_face = on_face || (pos[a] == '0) || last[a];
  end

  // x wraps every row, y when x wraps, z when both wrap
  always_comb begin
    pos_next[0] = last[0] ? '0 : pos[0] + PW'(1);
    pos_next[1] = pos[1];
    pos_next[2] = pos[2];
    if (last[0])
      pos_next[1] = last[1] ? '0 : pos[1] + PW'(1);
    if (last[0] && last[1])
      pos_next[2] = last[2] ? '0 : pos[2] + PW'(1);
  end

  always_comb begin
    fg_total_next = fg_total;
    face_hit_next = face_hit;
    for (int a = 0; a < 3; a++) begin
      box_min_next[a] = box_min[a];
      box_max_next[a] = box_max[a];
    end
    if (fg) begin
      if (fg_total != vbst_pkg::COUNT_SAT)
        fg_total_next = fg_total + vbst_pkg::COUNT_W'(1);
      if (on_face)
        face_hit_next = 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (pos[a] < box_min[a]) box_min_next[a] = pos[a];
        if (pos[a] > box_max[a]) box_max_next[a] = pos[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_total <= '0;
      face_hit <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        pos[a]     <= '0;
        box_min[a] <= '1;
        box_max[a] <= '0;
      end
    end else if (in_acc) begin
      for (int a = 0; a < 3; a++)
        pos[a] <= pos_next[a];
      if (vol_end) begin
        // start over for the next volume; snapshot keeps this one
        fg_total <= '0;
        face_hit <= 1'b0;
        for (int a = 0; a < 3; a++) begin
          box_min[a] <= '1;
          box_max[a] <= '0;
        end
      end else begin
        fg_total <= fg_total_next;
        face_hit <= face_hit_next;
        for (int a = 0; a < 3; a++) begin
          box_min[a] <= box_min_next[a];
          box_max[a] <= box_max_next[a];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Volume snapshot taken on the final voxel
  // --------------------------------------------------------------------------
  logic [vbst_pkg::COUNT_W-1:0] snap_fg;
  logic                         snap_face;
  logic [EW-1:0]                snap_ext [3];
  logic [EW-1:0]                ext_calc [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (fg_total_next != '0)
        ext_calc[a] = EW'(box_max_next[a]) - EW'(box_min_next[a]) + EW'(1);
      else
        ext_calc[a] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && vol_end) begin
      snap_fg   <= fg_total_next;
      snap_face <= face_hit_next;
      for (int a = 0; a < 3; a++)
        snap_ext[a] <= ext_calc[a];
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: pass 1 ext_x*ext_y, pass 2 previous product * ext_z
  // --------------------------------------------------------------------------
  logic [2*EW-1:0] mul_a;
  logic [EW-1:0]   mul_b;
  logic [PRW-1:0]  mul_p;
  logic [PRW-1:0]  prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      vbst_pkg::ST_MUL1: begin
        mul_a = (2*EW)'(snap_ext[0]);
        mul_b = snap_ext[1];
      end
      vbst_pkg::ST_MUL2: begin
        mul_a = prod[2*EW-1:0];
        mul_b = snap_ext[2];
      end
      default: ;
    endcase
    mul_p = PRW'(mul_a) * PRW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (state == vbst_pkg::ST_MUL1 || state == vbst_pkg::ST_MUL2)
      prod <= mul_p;
  end

  // --------------------------------------------------------------------------
  // Verdict, first applicable rule wins
  // --------------------------------------------------------------------------
  vbst_pkg::verdict_t verdict;
  logic [MW-1:0]      fg_x4;

  assign fg_x4 = MW'({snap_fg, 2'b00});

  always_comb begin
    if (snap_fg > max_size)
      verdict = vbst_pkg::VERD_TOO_LARGE;
    else if (snap_face)
      verdict = vbst_pkg::VERD_TOUCHES;
    else if (snap_fg == '0)
      verdict = vbst_pkg::VERD_EMPTY;
    else if (fg_x4 < MW'(prod))
      verdict = vbst_pkg::VERD_NOT_COMPACT;
    else
      verdict = vbst_pkg::VERD_SOLITARY;
  end

  // Reported extents saturate at the field's maximum
  function automatic logic [vbst_pkg::EXT_W-1:0] sat_ext(input logic [EW-1:0] e);
    logic [CW-1:0] ec;
    ec = CW'(e);
    if (ec > CW'(vbst_pkg::EXT_SAT))
      return vbst_pkg::EXT_SAT;
    return ec[vbst_pkg::EXT_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  logic out_valid, load_out;
  vbst_pkg::state_t state_next;

  assign load_out = (state == vbst_pkg::ST_DONE) && (!out_valid || out_ch.ready);

  always_comb begin
    state_next = state;
    case (state)
      vbst_pkg::ST_ACCUM: if (in_acc && vol_end) state_next = vbst_pkg::ST_MUL1;
      vbst_pkg::ST_MUL1:  state_next = vbst_pkg::ST_MUL2;
      vbst_pkg::ST_MUL2:  state_next = vbst_pkg::ST_DONE;
      vbst_pkg::ST_DONE:  if (load_out) state_next = vbst_pkg::ST_ACCUM;
      default:            state_next = vbst_pkg::ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vbst_pkg::ST_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out)
        out_valid <= 1'b1;
      else if (out_ch.ready)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.solitary <= (verdict == vbst_pkg::VERD_SOLITARY);
      out_ch.verdict  <= verdict;
      out_ch.fg_count <= snap_fg;
      out_ch.extent_x <= sat_ext(snap_ext[0]);
      out_ch.extent_y <= sat_ext(snap_ext[1]);
      out_ch.extent_z <= sat_ext(snap_ext[2]);
    end
  end

  assign out_ch.valid = out_valid;
  assign in_ch.ready  = (state == vbst_pkg::ST_ACCUM);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_end_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (in_acc && vol_end) |=> (state == vbst_pkg::ST_MUL1))
    else $error("final voxel did not start verdict sequence");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && vol_end) |=> (fg_total == '0 && !face_hit && pos[0] == '0
                             && pos[1] == '0 && pos[2] == '0))
    else $error("accumulators not cleared after final voxel");

  a_rose_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == vbst_pkg::ST_DONE))
    else $error("result appeared outside verdict sequence");

  a_solitary_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ch.solitary == (out_ch.verdict == vbst_pkg::VERD_SOLITARY)))
    else $error("solitary flag disagrees with verdict");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != vbst_pkg::ST_ACCUM) |-> !in_ch.ready)
    else $error("input taken during verdict sequence");

endmodule

/* dv/tb_volume_blob_solitary_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_volume_blob_solitary_test_top: testbench for the solitary-blob test
// Streams label volumes through the voxel channel with random idling on both
// channels. A scoreboard model walks the same raster, keeps the count, face
// flag and bounding box, and predicts one verdict per volume. Each verdict
// transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_volume_blob_solitary_test_top;
  import vbst_pkg::*;

  localparam int          MAX_DIM = MAX_DIM_DEFAULT;
  localparam int unsigned TO_END  = 32'hFFFF_FFFF;
  // idle margin once all verdicts are in
  localparam int unsigned SETTLE  = 8;

  typedef struct {
    logic               solitary;
    verdict_t           verdict;
    logic [COUNT_W-1:0] fg_count;
    logic [EXT_W-1:0]   ext_x;
    logic [EXT_W-1:0]   ext_y;
    logic [EXT_W-1:0]   ext_z;
  } blob_verdict_t;

  // a voxel forced to a given label at a given raster position
  typedef struct {
    int unsigned        x;
    int unsigned        y;
    int unsigned        z;
    logic [VOXEL_W-1:0] label;
  } mark_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  reg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vbst_in_if  in_ch ();
  vbst_out_if out_ch ();

  volume_blob_solitary_test_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Scoreboard model: register copies, raster walk and per-volume accumulators
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]   dim_set [3];
  logic [COUNT_W-1:0] size_limit;
  int unsigned        walk [3];     // x, y, z of the next voxel
  logic [COUNT_W-1:0] fg_seen;
  bit                 on_face;
  int unsigned        box_lo [3];
  int unsigned        box_hi [3];

  blob_verdict_t      verdicts_due [$];
  int unsigned        volumes_closed;
  int unsigned        voxels_sent;
  bit                 failed;

  // idling controls for each side
  bit                 in_gaps;
  bit                 out_gaps;
  int unsigned        ready_hold;

  // shape of the volume being sent: a box of foreground, sparse noise, marks
  int unsigned        blob_lo [3];
  int unsigned        blob_hi [3];
  int unsigned        blob_fill;    // percent inside the box
  int unsigned        noise_rate;   // per mille anywhere
  mark_t              marks [$];

  // 0 acts as 1, anything past MAX_DIM acts as MAX_DIM
  function automatic int unsigned span_of(logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic void restart_volume();
    walk    = '{0, 0, 0};
    fg_seen = '0;
    on_face = 1'b0;
    box_lo  = '{3{32'hFFFF_FFFF}};
    box_hi  = '{0, 0, 0};
  endfunction

  // one accepted voxel; pushes a verdict when it closes the volume
  function automatic void walk_voxel(logic [VOXEL_W-1:0] v);
    bit              at_end [3];
    int unsigned     ext [3];
    logic [63:0]     box_vol;
    blob_verdict_t   r;
    // a position at or past dim-1 counts as the last on that axis
    for (int a = 0; a < 3; a++) at_end[a] = walk[a] >= span_of(dim_set[a]) - 1;
    if (v != '0) begin
      if (fg_seen != COUNT_SAT) fg_seen++;
      for (int a = 0; a < 3; a++) begin
        if (walk[a] == 0 || at_end[a]) on_face = 1'b1;
        if (walk[a] < box_lo[a]) box_lo[a] = walk[a];
        if (walk[a] > box_hi[a]) box_hi[a] = walk[a];
      end
    end
    // x fastest, then y, then z
    for (int a = 0; a < 3; a++) begin
      if (!at_end[a]) begin
        walk[a]++;
        return;
      end
      walk[a] = 0;
    end
    ext = '{0, 0, 0};
    if (fg_seen != '0)
      for (int a = 0; a < 3; a++) ext[a] = box_hi[a] - box_lo[a] + 1;
    box_vol = 64'(ext[0]) * 64'(ext[1]) * 64'(ext[2]);
    // first rule that applies wins; ratio test as 4*count < box volume
    if (fg_seen > size_limit)               r.verdict = VERD_TOO_LARGE;
    else if (on_face)                       r.verdict = VERD_TOUCHES;
    else if (fg_seen == '0)                 r.verdict = VERD_EMPTY;
    else if (64'(fg_seen) * 64'd4 < box_vol) r.verdict = VERD_NOT_COMPACT;
    else                                    r.verdict = VERD_SOLITARY;
    r.solitary = (r.verdict == VERD_SOLITARY);
    r.fg_count = fg_seen;
    r.ext_x    = (ext[0] > EXT_SAT) ? EXT_SAT : EXT_W'(ext[0]);
    r.ext_y    = (ext[1] > EXT_SAT) ? EXT_SAT : EXT_W'(ext[1]);
    r.ext_z    = (ext[2] > EXT_SAT) ? EXT_SAT : EXT_W'(ext[2]);
    verdicts_due.push_back(r);
    volumes_closed++;
    restart_volume();
  endfunction

  // --------------------------------------------------------------------------
  // Volume shaping
  // --------------------------------------------------------------------------
  function automatic void clear_pattern();
    blob_lo    = '{1, 1, 1};
    blob_hi    = '{0, 0, 0};
    blob_fill  = 0;
    noise_rate = 0;
    marks.delete();
  endfunction

  // label for the voxel at the current walk position
  function automatic logic [VOXEL_W-1:0] pick_voxel();
    bit in_blob;
    foreach (marks[i])
      if (marks[i].x == walk[0] && marks[i].y == walk[1] && marks[i].z == walk[2])
        return marks[i].label;
    in_blob = 1'b1;
    for (int a = 0; a < 3; a++)
      if (walk[a] < blob_lo[a] || walk[a] > blob_hi[a]) in_blob = 1'b0;
    if (in_blob && $urandom_range(1, 100) <= blob_fill)
      return VOXEL_W'($urandom_range(1, 255));
    if ($urandom_range(1, 1000) <= noise_rate)
      return VOXEL_W'($urandom_range(1, 255));
    return '0;
  endfunction

  // mostly a blob clear of the faces, sometimes noise or nothing
  function automatic void shape_volume();
    int unsigned s;
    clear_pattern();
    case ($urandom_range(0, 9))
      0: ;
      1, 2: noise_rate = $urandom_range(5, 300);
      default: begin
        for (int a = 0; a < 3; a++) begin
          s = span_of(dim_set[a]);
          if (s >= 3) begin
            blob_lo[a] = $urandom_range(1, s - 2);
            blob_hi[a] = $urandom_range(blob_lo[a], s - 2);
          end else begin
            blob_lo[a] = 0;
            blob_hi[a] = s - 1;
          end
        end
        case ($urandom_range(0, 3))
          0: blob_fill = 100;
          1: blob_fill = 70;
          2: blob_fill = 35;
          default: blob_fill = 12;
        endcase
        if ($urandom_range(0, 4) == 0) noise_rate = $urandom_range(1, 40);
      end
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return COUNT_SAT;
      2: return COUNT_W'($urandom);
      3: return 25'h100_0000;
      default: return COUNT_W'($urandom_range(0, 60));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // one voxel transaction, with an optional idle burst in front of it
  task automatic send_voxel(logic [VOXEL_W-1:0] v);
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.voxel <= v;
    do @(posedge clk); while (!in_ch.ready);
    walk_voxel(v);
    voxels_sent++;
  endtask

  // stops after the volume closes or after limit voxels
  task automatic send_volume(int unsigned limit);
    int unsigned closed_at_start;
    closed_at_start = volumes_closed;
    for (int unsigned n = 0; n < limit && volumes_closed == closed_at_start; n++)
      send_voxel(pick_voxel());
  endtask

  // input quiet, all verdicts in, then the multiply pipe given time to empty
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_DIM_X:    dim_set[0] = val[DIM_W-1:0];
      REG_DIM_Y:    dim_set[1] = val[DIM_W-1:0];
      REG_DIM_Z:    dim_set[2] = val[DIM_W-1:0];
      REG_MAX_SIZE: size_limit = val[COUNT_W-1:0];
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(logic [CFG_DATA_W-1:0] dx, logic [CFG_DATA_W-1:0] dy,
                             logic [CFG_DATA_W-1:0] dz, logic [CFG_DATA_W-1:0] msz);
    wait_idle();
    write_reg(REG_DIM_X, dx);
    write_reg(REG_DIM_Y, dy);
    write_reg(REG_DIM_Z, dz);
    write_reg(REG_MAX_SIZE, msz);
  endtask

  // verdict side back-pressure: random bursts with ready held low
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (out_gaps && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Verdict checker
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [COUNT_W-1:0] want,
                                      logic [COUNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : verdict_check
    blob_verdict_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict: none expected, got %0d", out_ch.verdict);
        failed = 1'b1;
      end else begin
        want = verdicts_due.pop_front();
        check_field("solitary", want.solitary, out_ch.solitary);
        check_field("verdict",  want.verdict,  out_ch.verdict);
        check_field("fg_count", want.fg_count, out_ch.fg_count);
        check_field("extent_x", want.ext_x,    out_ch.extent_x);
        check_field("extent_y", want.ext_y,    out_ch.extent_y);
        check_field("extent_z", want.ext_z,    out_ch.extent_z);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset dims are 64 each: too big to finish, so walk into the volume, then
  // shrink to 3x3x3; position and accumulators must survive the writes and
  // the stale x position counts as the last one on its axis
  task automatic test_reset_and_resize();
    clear_pattern();
    noise_rate = 300;
    send_volume(70);
    wait_idle();
    write_reg(REG_DIM_X, 3);
    write_reg(REG_DIM_Y, 3);
    write_reg(REG_DIM_Z, 3);
    send_volume(TO_END);
  endtask

  // one-voxel volumes; dim 0 acts as 1, upper data bits of a dim are dropped
  task automatic test_unit_volumes();
    reconfigure(0, 25'h1FF_FE01, 0, 1000);
    clear_pattern();
    send_volume(TO_END);                         // empty
    marks.push_back(mark_t'{0, 0, 0, 8'hFF});
    send_volume(TO_END);                         // on every face
    marks[0].label = 8'h01;
    send_volume(TO_END);
    wait_idle();
    write_reg(REG_MAX_SIZE, 0);
    marks[0].label = 8'h80;
    send_volume(TO_END);                         // too large beats face
    clear_pattern();
    send_volume(TO_END);                         // empty, zero not above zero
  endtask

  task automatic test_verdict_rules();
    // lone centre voxel
    reconfigure(3, 3, 3, COUNT_SAT);
    clear_pattern();
    marks.push_back(mark_t'{1, 1, 1, 8'h5A});
    send_volume(TO_END);
    // 2 voxels in a 2x2x2 box: 4*count equals box volume, still solitary
    reconfigure(4, 4, 4, COUNT_SAT);
    clear_pattern();
    marks.push_back(mark_t'{1, 1, 1, 8'hA5});
    marks.push_back(mark_t'{2, 2, 2, 8'h3C});
    send_volume(TO_END);
    // same blob just over the size limit
    wait_idle();
    write_reg(REG_MAX_SIZE, 1);
    send_volume(TO_END);
    // 2 voxels in a 3x3x1 box: one short of compact; count equals the limit
    reconfigure(5, 5, 3, 2);
    clear_pattern();
    marks.push_back(mark_t'{1, 1, 1, 8'hC3});
    marks.push_back(mark_t'{3, 3, 1, 8'h7E});
    send_volume(TO_END);
    // full volume: on the faces, count at the limit
    reconfigure(3, 3, 3, 27);
    clear_pattern();
    blob_lo   = '{0, 0, 0};
    blob_hi   = '{2, 2, 2};
    blob_fill = 100;
    send_volume(TO_END);
  endtask

  // widest axes: dims past MAX_DIM clamp, extents reach 256
  task automatic test_wide_volumes();
    reconfigure(511, 1, 1, COUNT_SAT);
    clear_pattern();
    noise_rate = 20;
    marks.push_back(mark_t'{0, 0, 0, 8'hFF});
    marks.push_back(mark_t'{255, 0, 0, 8'hA5});
    send_volume(TO_END);
    reconfigure(256, 3, 3, 25'h100_0000);
    clear_pattern();
    blob_lo   = '{1, 1, 1};
    blob_hi   = '{254, 1, 1};
    blob_fill = 100;
    send_volume(TO_END);
    reconfigure(1, 257, 1, 0);
    clear_pattern();
    marks.push_back(mark_t'{0, 0, 0, 8'h11});
    marks.push_back(mark_t'{0, 255, 0, 8'h22});
    send_volume(TO_END);
  endtask

  task automatic test_random_volumes();
    int unsigned first_voxel;
    int unsigned first_volume;
    int unsigned d [3];
    int unsigned big;
    reg_idx_t    idx;
    first_voxel  = voxels_sent;
    first_volume = volumes_closed;
    while (voxels_sent - first_voxel < 600 || volumes_closed - first_volume < 40) begin
      // last stretch runs flat out on both sides
      if (volumes_closed - first_volume >= 32 && voxels_sent - first_voxel >= 450) begin
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
      end else begin
        in_gaps  = $urandom_range(0, 3) != 0;
        out_gaps = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 2) == 0) begin
        for (int a = 0; a < 3; a++) d[a] = $urandom_range(1, 5);
        case ($urandom_range(0, 7))
          0: begin
            // one long axis, the others thin to keep the volume short
            big = $urandom_range(0, 2);
            for (int a = 0; a < 3; a++) d[a] = $urandom_range(1, 2);
            d[big] = $urandom_range(200, 511);
          end
          1: d[$urandom_range(0, 2)] = 0;
          default: ;
        endcase
        reconfigure(d[0], d[1], d[2], pick_limit());
      end
      shape_volume();
      if ($urandom_range(0, 7) == 0) begin
        // retune part way through a volume
        send_volume($urandom_range(1, 30));
        wait_idle();
        idx = reg_idx_t'($urandom_range(0, 3));
        write_reg(idx, idx == REG_MAX_SIZE ? CFG_DATA_W'(pick_limit())
                                           : CFG_DATA_W'($urandom_range(0, 7)));
      end
      send_volume(TO_END);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_DIM_X;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.voxel  = '0;
    out_ch.ready = 1'b0;
    ready_hold   = 0;
    in_gaps      = 1'b1;
    out_gaps     = 1'b1;
    failed       = 1'b0;
    voxels_sent    = 0;
    volumes_closed = 0;
    dim_set      = '{DIM_RESET, DIM_RESET, DIM_RESET};
    size_limit   = MAX_SIZE_RESET;
    restart_volume();
    clear_pattern();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_and_resize();
    test_unit_volumes();
    test_verdict_rules();
    test_wide_volumes();
    test_random_volumes();

    wait_idle();
    if (!failed)
      $display("volume_blob_solitary_test_top verification clean");
    else
      $display("volume_blob_solitary_test_top verification failed");
    $finish;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("volume_blob_solitary_test_top verification failed");
    $finish;
  end

endmodule
